### rtl/kdlr_pkg.sv
// Shared constants, types and helpers of the key debounce block.
package kdlr_pkg;

   // Build-time configuration
   localparam int FILTER_TIME      = 5;
   localparam int NUM_KEYS         = 4;
   localparam int ACTIVE_HIGH_MASK = 1;

   // Fixed geometry
   localparam int KEY_SLOTS   = 4;
   localparam int EVT_SLOTS   = 2 * KEY_SLOTS;
   localparam int SLOT_W      = $clog2(EVT_SLOTS);
   localparam int KEY_W       = $clog2(KEY_SLOTS);
   localparam int CODE_W      = 4;
   localparam int LONG_W      = 16;
   localparam int SPEED_W     = 8;
   localparam int CNT_W       = 8;
   localparam int CSR_IDX_W   = 4;
   localparam int CSR_DATA_W  = 16;

   // Debounce counter landmarks
   localparam logic [CNT_W-1:0] FILTER_MID = CNT_W'(FILTER_TIME);
   localparam logic [CNT_W-1:0] FILTER_TOP = CNT_W'(2 * FILTER_TIME);
   localparam logic [CNT_W-1:0] DEB_RESET  = CNT_W'(FILTER_TIME / 2);

   // Register reset values
   localparam logic [LONG_W-1:0]  LONG_TIME_RESET    = LONG_W'(100);
   localparam logic [SPEED_W-1:0] REPEAT_SPEED_RESET = '0;

   // Register map
   localparam logic [CSR_IDX_W-1:0] REG_LONG_TIME_BASE    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_SPEED_BASE = CSR_IDX_W'(4);

   // Event kinds, offset from 3*key
   localparam logic [1:0] EVT_NONE    = 2'd0;
   localparam logic [1:0] EVT_PRESS   = 2'd1;
   localparam logic [1:0] EVT_RELEASE = 2'd2;
   localparam logic [1:0] EVT_LONG    = 2'd3;

   localparam logic [CODE_W-1:0] CODE_NONE = '0;

   // Events of one key in one tick: press/release first, then repeat/long
   typedef struct packed {
      logic ev0;
      logic ev0_release;
      logic ev1;
      logic ev1_long;
   } key_evt_type;

   // Event code of a key and an event kind
   function automatic logic [CODE_W-1:0] evt_code(input logic [KEY_W-1:0] key,
                                                  input logic [1:0] kind);
      evt_code = CODE_W'(3 * int'(key)) + CODE_W'(kind);
   endfunction

endpackage

### rtl/key_debounce_long_repeat_top.sv
// Top level of the four-key debouncer with long-press and auto-repeat events.
// Each request is one scan tick carrying the raw key levels. All key state
// updates at the accepting edge and the tick's events land in a result register.
// Events then leave one per cycle in key order while rsp_stall is low, so a tick
// gives one output item per event (one item for a quiet tick, at most eight); the
// next tick is accepted in the same cycle that the last event of the previous one
// is taken, as set by the single result register and its one-event-per-cycle
// serializer. Registers 0-3 set each key's long-press time and 4-7 its repeat
// speed; writes to other indexes are dropped, and csr_ready is always high.
module key_debounce_long_repeat_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [kdlr_pkg::KEY_SLOTS-1:0]      req_key_levels,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kdlr_pkg::CODE_W-1:0]         rsp_event_code,
   output logic [kdlr_pkg::KEY_SLOTS-1:0]      rsp_pressed_mask,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kdlr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [kdlr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   logic [kdlr_pkg::LONG_W-1:0]    long_time_ff [kdlr_pkg::KEY_SLOTS];
   logic [kdlr_pkg::SPEED_W-1:0]   repeat_speed_ff [kdlr_pkg::KEY_SLOTS];
   logic [kdlr_pkg::KEY_SLOTS-1:0] wr_long, wr_speed;
   logic [kdlr_pkg::KEY_SLOTS-1:0] pressed_next;
   kdlr_pkg::key_evt_type          evt [kdlr_pkg::KEY_SLOTS];
   logic [kdlr_pkg::EVT_SLOTS-1:0] slot_vec, alt_vec;
   logic                           free;
   logic                           step;

   assign csr_ready = 1'b1;
   assign req_stall = !free;
   assign step      = req_valid && free;

   // Register writes and per-key logic
   for (genvar k = 0; k < kdlr_pkg::KEY_SLOTS; k++) begin : g_key
      assign wr_long[k]  = csr_valid &&
         (csr_index == kdlr_pkg::REG_LONG_TIME_BASE + kdlr_pkg::CSR_IDX_W'(k));
      assign wr_speed[k] = csr_valid &&
         (csr_index == kdlr_pkg::REG_REPEAT_SPEED_BASE + kdlr_pkg::CSR_IDX_W'(k));

      always_ff @(posedge clock) begin
         if (reset) begin
            long_time_ff[k]    <= kdlr_pkg::LONG_TIME_RESET;
            repeat_speed_ff[k] <= kdlr_pkg::REPEAT_SPEED_RESET;
         end else begin
            if (wr_long[k]) begin
               long_time_ff[k] <= csr_wdata[kdlr_pkg::LONG_W-1:0];
            end
            if (wr_speed[k]) begin
               repeat_speed_ff[k] <= csr_wdata[kdlr_pkg::SPEED_W-1:0];
            end
         end
      end

      if (k < kdlr_pkg::NUM_KEYS) begin : g_used
         kdlr_key u_key (
            .clock        (clock),
            .reset        (reset),
            .step         (step),
            .level        (req_key_levels[k]),
            .active_high  (kdlr_pkg::ACTIVE_HIGH_MASK[k]),
            .cfg_clear    (wr_long[k] || wr_speed[k]),
            .long_time    (long_time_ff[k]),
            .repeat_speed (repeat_speed_ff[k]),
            .pressed_next (pressed_next[k]),
            .evt          (evt[k])
         );
      end else begin : g_unused
         assign pressed_next[k] = 1'b0;
         assign evt[k]          = '0;
      end

      // Two event slots per key
      assign slot_vec[2*k]   = evt[k].ev0;
      assign alt_vec[2*k]    = evt[k].ev0_release;
      assign slot_vec[2*k+1] = evt[k].ev1;
      assign alt_vec[2*k+1]  = evt[k].ev1_long;
   end

   // Result register and serializer
   kdlr_out u_out (
      .clock            (clock),
      .reset            (reset),
      .load             (step),
      .slot_vec         (slot_vec),
      .alt_vec          (alt_vec),
      .mask             (pressed_next),
      .free             (free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_code   (rsp_event_code),
      .rsp_pressed_mask (rsp_pressed_mask),
      .rsp_last         (rsp_last)
   );

endmodule

### rtl/kdlr_key.sv
// One key: debounce counter, pressed flag, long-press and repeat counters.
module kdlr_key (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               step,
   input  logic                               level,
   input  logic                               active_high,
   input  logic                               cfg_clear,
   input  logic [kdlr_pkg::LONG_W-1:0]        long_time,
   input  logic [kdlr_pkg::SPEED_W-1:0]       repeat_speed,
   output logic                               pressed_next,
   output kdlr_pkg::key_evt_type              evt
);

   logic [kdlr_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                         pressed_ff, pressed_in;
   logic [kdlr_pkg::LONG_W-1:0]  long_ff, long_in, long_inc;
   logic [kdlr_pkg::SPEED_W-1:0] rep_ff, rep_in, rep_inc;

   assign long_inc     = long_ff + 1'b1;
   assign rep_inc      = rep_ff + 1'b1;
   assign pressed_next = pressed_in;

   // Next state and events for this tick
   always_comb begin
      cnt_in     = cnt_ff;
      pressed_in = pressed_ff;
      long_in    = long_ff;
      rep_in     = rep_ff;
      evt        = '0;
      if (level == active_high) begin
         if (cnt_ff < kdlr_pkg::FILTER_MID) begin
            cnt_in = kdlr_pkg::FILTER_MID;
         end else if (cnt_ff < kdlr_pkg::FILTER_TOP) begin
            cnt_in = cnt_ff + 1'b1;
         end else begin
            // settled down
            if (!pressed_ff) begin
               pressed_in = 1'b1;
               evt.ev0    = 1'b1;
            end
            if (long_time != '0 && long_ff < long_time) begin
               long_in = long_inc;
               if (long_inc == long_time) begin
                  if (repeat_speed != '0) begin
                     long_in = '0;
                     rep_in  = rep_inc;
                     if (rep_inc >= repeat_speed) begin
                        rep_in  = '0;
                        evt.ev1 = 1'b1;
                     end
                  end else begin
                     evt.ev1      = 1'b1;
                     evt.ev1_long = 1'b1;
                  end
               end
            end
         end
      end else begin
         if (cnt_ff > kdlr_pkg::FILTER_MID) begin
            cnt_in = kdlr_pkg::FILTER_MID;
         end else if (cnt_ff != '0) begin
            cnt_in = cnt_ff - 1'b1;
         end else if (pressed_ff) begin
            pressed_in      = 1'b0;
            evt.ev0         = 1'b1;
            evt.ev0_release = 1'b1;
         end
         long_in = '0;
         rep_in  = '0;
      end
   end

   // State update on each accepted tick; a register write restarts the repeat count
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= kdlr_pkg::DEB_RESET;
         pressed_ff <= 1'b0;
         long_ff    <= '0;
         rep_ff     <= '0;
      end else begin
         if (step) begin
            cnt_ff     <= cnt_in;
            pressed_ff <= pressed_in;
            long_ff    <= long_in;
         end
         if (cfg_clear) begin
            rep_ff <= '0;
         end else if (step) begin
            rep_ff <= rep_in;
         end
      end
   end

endmodule

### rtl/kdlr_out.sv
// Result register of one tick and the serializer that sends its events in key order.
module kdlr_out (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  logic [kdlr_pkg::EVT_SLOTS-1:0]      slot_vec,
   input  logic [kdlr_pkg::EVT_SLOTS-1:0]      alt_vec,
   input  logic [kdlr_pkg::KEY_SLOTS-1:0]      mask,
   output logic                                free,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [kdlr_pkg::CODE_W-1:0]         rsp_event_code,
   output logic [kdlr_pkg::KEY_SLOTS-1:0]      rsp_pressed_mask,
   output logic                                rsp_last
);

   logic                               valid_ff;
   logic [kdlr_pkg::EVT_SLOTS-1:0]     pend_ff, pend_in;
   logic [kdlr_pkg::EVT_SLOTS-1:0]     alt_ff;
   logic [kdlr_pkg::KEY_SLOTS-1:0]     mask_ff;
   logic [kdlr_pkg::SLOT_W-1:0]        sel;
   logic                               found;
   logic                               take;
   logic [1:0]                         kind;

   // Lowest pending event slot
   always_comb begin
      sel   = '0;
      found = 1'b0;
      for (int i = kdlr_pkg::EVT_SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            sel   = kdlr_pkg::SLOT_W'(i);
            found = 1'b1;
         end
      end
   end

   // Even slots carry press or release, odd slots repeat or long
   always_comb begin
      if (!sel[0]) begin
         kind = alt_ff[sel] ? kdlr_pkg::EVT_RELEASE : kdlr_pkg::EVT_PRESS;
      end else begin
         kind = alt_ff[sel] ? kdlr_pkg::EVT_LONG : kdlr_pkg::EVT_PRESS;
      end
   end

   always_comb begin
      pend_in      = pend_ff;
      pend_in[sel] = 1'b0;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_pressed_mask = mask_ff;
   assign rsp_event_code   = found ? kdlr_pkg::evt_code(sel[kdlr_pkg::SLOT_W-1:1], kind)
                                   : kdlr_pkg::CODE_NONE;
   assign rsp_last         = (pend_in == '0);
   assign take             = valid_ff && !rsp_stall;
   assign free             = !valid_ff || (take && rsp_last);

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (take && rsp_last) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pend_ff <= slot_vec;
         alt_ff  <= alt_vec;
         mask_ff <= mask;
      end else if (take) begin
         pend_ff <= pend_in;
      end
   end

   // A new tick only lands in an empty or draining result register
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("tick loaded over undelivered events");

   // A quiet result is always the only one of its tick
   a_quiet_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_code == kdlr_pkg::CODE_NONE) |-> rsp_last)
      else $error("quiet result not marked last");

   // Final result taken with nothing new leaves the output empty
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (take && rsp_last && !load) |=> !rsp_valid)
      else $error("output still valid after last event");

   // Each non-final result taken retires exactly one pending event
   a_retire: assert property (@(posedge clock) disable iff (reset)
      (take && !rsp_last && !load) |=>
         (rsp_valid && $countones(pend_ff) == $countones($past(pend_ff)) - 1))
      else $error("pending events not retired one at a time");

endmodule

### tb/tb_top.sv
// Self-checking testbench for the four-key debouncer with long-press and auto-repeat events.
`timescale 1ns / 1ps

module tb_top;

   localparam int CLK_PERIOD   = 8;
   localparam int RESET_CYCLES = 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int GAP_MAX      = 18;
   localparam int PHASES       = 7;
   localparam int PHASE_TICKS  = 26;
   localparam int REG_LIMIT    = int'(kdlr_pkg::REG_REPEAT_SPEED_BASE) + kdlr_pkg::KEY_SLOTS;

   localparam logic [kdlr_pkg::KEY_SLOTS-1:0] ACTIVE_LEVELS =
      kdlr_pkg::KEY_SLOTS'(kdlr_pkg::ACTIVE_HIGH_MASK);

   // One event leaving the block
   typedef struct packed {
      logic [kdlr_pkg::CODE_W-1:0]    code;
      logic [kdlr_pkg::KEY_SLOTS-1:0] mask;
      logic                           last;
   } key_event_type;

   // Key-state predictor plus the queue of events still owed by the block
   class key_event_scoreboard;
      logic [kdlr_pkg::LONG_W-1:0]    long_time    [kdlr_pkg::KEY_SLOTS];
      logic [kdlr_pkg::SPEED_W-1:0]   repeat_speed [kdlr_pkg::KEY_SLOTS];
      logic [kdlr_pkg::CNT_W-1:0]     deb_cnt      [kdlr_pkg::KEY_SLOTS];
      logic [kdlr_pkg::LONG_W-1:0]    long_cnt     [kdlr_pkg::KEY_SLOTS];
      logic [kdlr_pkg::SPEED_W-1:0]   rep_cnt      [kdlr_pkg::KEY_SLOTS];
      logic [kdlr_pkg::KEY_SLOTS-1:0] pressed;
      key_event_type                  pending_events[$];
      int                             fail_count;
      int                             tick_count;
      int                             event_count;
      int                             quiet_count;

      function new();
         for (int k = 0; k < kdlr_pkg::KEY_SLOTS; k++) begin
            long_time[k]    = kdlr_pkg::LONG_TIME_RESET;
            repeat_speed[k] = kdlr_pkg::REPEAT_SPEED_RESET;
            deb_cnt[k]      = kdlr_pkg::DEB_RESET;
            long_cnt[k]     = '0;
            rep_cnt[k]      = '0;
         end
         pressed     = '0;
         fail_count  = 0;
         tick_count  = 0;
         event_count = 0;
         quiet_count = 0;
      endfunction

      function logic [kdlr_pkg::CODE_W-1:0] code_of(int key, logic [1:0] kind);
         return kdlr_pkg::CODE_W'(3 * key + int'(kind));
      endfunction

      // Register write; either register of a key also clears its repeat count
      function void set_register(logic [kdlr_pkg::CSR_IDX_W-1:0] idx,
                                 logic [kdlr_pkg::CSR_DATA_W-1:0] data);
         int key;
         if (int'(idx) < int'(kdlr_pkg::REG_REPEAT_SPEED_BASE)) begin
            key = int'(idx) - int'(kdlr_pkg::REG_LONG_TIME_BASE);
            long_time[key] = data[kdlr_pkg::LONG_W-1:0];
            rep_cnt[key]   = '0;
         end else if (int'(idx) < REG_LIMIT) begin
            key = int'(idx) - int'(kdlr_pkg::REG_REPEAT_SPEED_BASE);
            repeat_speed[key] = data[kdlr_pkg::SPEED_W-1:0];
            rep_cnt[key]      = '0;
         end
      endfunction

      // One accepted scan tick: advance every key and queue the events it causes
      function void scan_tick(logic [kdlr_pkg::KEY_SLOTS-1:0] levels);
         logic [kdlr_pkg::CODE_W-1:0] codes[$];
         logic                        down;
         key_event_type               ev;
         tick_count++;
         for (int k = 0; k < kdlr_pkg::NUM_KEYS; k++) begin
            down = (levels[k] == ACTIVE_LEVELS[k]);
            if (down) begin
               if (deb_cnt[k] < kdlr_pkg::FILTER_MID) begin
                  deb_cnt[k] = kdlr_pkg::FILTER_MID;
               end else if (deb_cnt[k] < kdlr_pkg::FILTER_TOP) begin
                  deb_cnt[k] = deb_cnt[k] + 1'b1;
               end else begin
                  if (!pressed[k]) begin
                     pressed[k] = 1'b1;
                     codes.push_back(code_of(k, kdlr_pkg::EVT_PRESS));
                  end
                  // long counter stops once at or above the long time
                  if (long_time[k] != '0 && long_cnt[k] < long_time[k]) begin
                     long_cnt[k] = long_cnt[k] + 1'b1;
                     if (long_cnt[k] == long_time[k]) begin
                        if (repeat_speed[k] != '0) begin
                           long_cnt[k] = '0;
                           rep_cnt[k]  = rep_cnt[k] + 1'b1;
                           if (rep_cnt[k] >= repeat_speed[k]) begin
                              rep_cnt[k] = '0;
                              codes.push_back(code_of(k, kdlr_pkg::EVT_PRESS));
                           end
                        end else begin
                           codes.push_back(code_of(k, kdlr_pkg::EVT_LONG));
                        end
                     end
                  end
               end
            end else begin
               if (deb_cnt[k] > kdlr_pkg::FILTER_MID) begin
                  deb_cnt[k] = kdlr_pkg::FILTER_MID;
               end else if (deb_cnt[k] != '0) begin
                  deb_cnt[k] = deb_cnt[k] - 1'b1;
               end else if (pressed[k]) begin
                  pressed[k] = 1'b0;
                  codes.push_back(code_of(k, kdlr_pkg::EVT_RELEASE));
               end
               long_cnt[k] = '0;
               rep_cnt[k]  = '0;
            end
         end
         // quiet tick still produces one item
         if (codes.size() == 0) begin
            ev.code = kdlr_pkg::CODE_NONE;
            ev.mask = pressed;
            ev.last = 1'b1;
            pending_events.push_back(ev);
         end
         for (int i = 0; i < codes.size(); i++) begin
            ev.code = codes[i];
            ev.mask = pressed;
            ev.last = (i == codes.size() - 1);
            pending_events.push_back(ev);
         end
      endfunction

      // Compare one accepted event with the oldest one owed
      function void check_event(logic [kdlr_pkg::CODE_W-1:0] code,
                                logic [kdlr_pkg::KEY_SLOTS-1:0] mask, logic last);
         key_event_type want;
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event code=%0d mask=%b last=%b",
                     $time, code, mask, last);
            fail_count++;
            return;
         end
         want = pending_events.pop_front();
         event_count++;
         if (want.code == kdlr_pkg::CODE_NONE) quiet_count++;
         if (code !== want.code) begin
            $display("%0t: event_code mismatch, expected %0d, actual %0d",
                     $time, want.code, code);
            fail_count++;
         end
         if (mask !== want.mask) begin
            $display("%0t: pressed_mask mismatch, expected %b, actual %b",
                     $time, want.mask, mask);
            fail_count++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch, expected %b, actual %b", $time, want.last, last);
            fail_count++;
         end
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [kdlr_pkg::KEY_SLOTS-1:0]  req_key_levels = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [kdlr_pkg::CODE_W-1:0]     rsp_event_code;
   logic [kdlr_pkg::KEY_SLOTS-1:0]  rsp_pressed_mask;
   logic                            rsp_last;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [kdlr_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [kdlr_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   key_event_scoreboard             sb;
   logic [kdlr_pkg::KEY_SLOTS-1:0]  held_keys = '0;
   bit                              tx_calm = 1'b0;
   bit                              rx_calm = 1'b0;
   int                              rsp_hold = 0;
   int                              cycle_count = 0;
   int                              setting_count = 0;

   key_debounce_long_repeat_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_key_levels   (req_key_levels),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_code   (rsp_event_code),
      .rsp_pressed_mask (rsp_pressed_mask),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d events outstanding", $time,
                  sb.pending_events.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Event receiver: check each accepted event, then stall for the drawn cycles
   always @(posedge clock) begin : rx_side
      int draw;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_event(rsp_event_code, rsp_pressed_mask, rsp_last);
            draw = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
            rsp_stall <= (draw != 0);
            rsp_hold  <= (draw != 0) ? draw - 1 : 0;
         end else if (rsp_hold > 0) begin
            rsp_hold <= rsp_hold - 1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Send one scan tick after a random gap; valid stays high afterwards
   task automatic send_tick(input logic [kdlr_pkg::KEY_SLOTS-1:0] levels);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_key_levels <= levels;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.scan_tick(levels);
   endtask

   // Raw levels for a set of keys held down
   function automatic logic [kdlr_pkg::KEY_SLOTS-1:0] levels_for(
      input logic [kdlr_pkg::KEY_SLOTS-1:0] down);
      return ~(down ^ ACTIVE_LEVELS);
   endfunction

   // Held keys change rarely; occasional bounce and occasional noise ticks
   function automatic logic [kdlr_pkg::KEY_SLOTS-1:0] random_levels();
      logic [kdlr_pkg::KEY_SLOTS-1:0] down;
      for (int k = 0; k < kdlr_pkg::KEY_SLOTS; k++)
         if ($urandom_range(0, 15) == 0) held_keys[k] = ~held_keys[k];
      down = held_keys;
      if ($urandom_range(0, 9) == 0)
         down[kdlr_pkg::KEY_W'($urandom_range(0, kdlr_pkg::KEY_SLOTS - 1))] ^= 1'b1;
      if ($urandom_range(0, 11) == 0) down = kdlr_pkg::KEY_SLOTS'($urandom);
      return levels_for(down);
   endfunction

   // Register write; csr_valid is left high for a following write
   task automatic csr_write(input logic [kdlr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [kdlr_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_register(idx, data);
   endtask

   // Write every key's long time and repeat speed, plus one ignored index
   task automatic configure_keys(input logic [kdlr_pkg::LONG_W-1:0] lt[kdlr_pkg::KEY_SLOTS],
                                 input logic [kdlr_pkg::SPEED_W-1:0] rs[kdlr_pkg::KEY_SLOTS]);
      for (int k = 0; k < kdlr_pkg::KEY_SLOTS; k++) begin
         csr_write(kdlr_pkg::REG_LONG_TIME_BASE + kdlr_pkg::CSR_IDX_W'(k),
                   kdlr_pkg::CSR_DATA_W'(lt[k]));
         csr_write(kdlr_pkg::REG_REPEAT_SPEED_BASE + kdlr_pkg::CSR_IDX_W'(k),
                   kdlr_pkg::CSR_DATA_W'(rs[k]));
      end
      csr_write(kdlr_pkg::CSR_IDX_W'(REG_LIMIT +
                   $urandom_range(0, (1 << kdlr_pkg::CSR_IDX_W) - 1 - REG_LIMIT)),
                kdlr_pkg::CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // Stop sending and let every owed event come out
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [kdlr_pkg::LONG_W-1:0]  lt[kdlr_pkg::KEY_SLOTS];
      logic [kdlr_pkg::SPEED_W-1:0] rs[kdlr_pkg::KEY_SLOTS];
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: long time 1 everywhere, mixed repeat speeds, so the press
      // tick carries press plus long/repeat on keys 0-2 (key 3 repeats later)
      lt = '{kdlr_pkg::LONG_W'(1), kdlr_pkg::LONG_W'(1),
             kdlr_pkg::LONG_W'(1), kdlr_pkg::LONG_W'(1)};
      rs = '{kdlr_pkg::SPEED_W'(0), kdlr_pkg::SPEED_W'(1),
             kdlr_pkg::SPEED_W'(0), kdlr_pkg::SPEED_W'(2)};
      configure_keys(lt, rs);
      send_tick(levels_for('0));
      repeat (9) send_tick(levels_for('1));
      // bounce while held, then full release on all keys in one tick
      send_tick(levels_for('0));
      send_tick(levels_for('1));
      repeat (8) send_tick(levels_for('0));
      send_tick('0);
      send_tick('1);
      wait_idle();

      // Random phases; the sender pauses for a full drain at each boundary
      held_keys = '1;
      for (int p = 0; p < PHASES; p++) begin
         for (int k = 0; k < kdlr_pkg::KEY_SLOTS; k++) begin
            case (p)
               0: begin
                  lt[k] = '1;
                  rs[k] = '1;
               end
               1: begin
                  // below the count reached while held: counter stalls
                  lt[k] = kdlr_pkg::LONG_W'($urandom_range(1, 3));
                  rs[k] = '0;
               end
               2: begin
                  lt[k] = '0;
                  rs[k] = '0;
               end
               3: begin
                  lt[k] = kdlr_pkg::LONG_W'(1);
                  rs[k] = kdlr_pkg::SPEED_W'(1);
               end
               default: begin
                  lt[k] = ($urandom_range(0, 3) == 0)
                          ? kdlr_pkg::LONG_W'($urandom_range(9, 40))
                          : kdlr_pkg::LONG_W'($urandom_range(1, 8));
                  rs[k] = kdlr_pkg::SPEED_W'($urandom_range(0, 4));
               end
            endcase
         end
         configure_keys(lt, rs);
         tx_calm = (p == 3) || (p == 6);
         rx_calm = (p == 3) || (p == 5);
         repeat (PHASE_TICKS) send_tick(random_levels());
         wait_idle();
      end

      $display("Covered %0d scan ticks under %0d register settings; %0d events checked",
               sb.tick_count, setting_count, sb.event_count);
      $display("(%0d quiet ticks), with bounce, long-press, repeat and stalled long counts.",
               sb.quiet_count);
      if (sb.fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
